### hw/rtl/joystick_axis_conditioner_defines.svh
// ----------------------------------------------------------------------------
// Joystick axis conditioner: assertion macros
// Shared property forms for the conditioner's RTL checks.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_AXIS_CONDITIONER_DEFINES_SVH
`define JOYSTICK_AXIS_CONDITIONER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, quiet during reset
`define JAC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, quiet during reset
`define JAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/jac_pkg.sv
// ----------------------------------------------------------------------------
// Joystick axis conditioner package
// Window size, arithmetic widths, reciprocal constants and stage structs.
// ----------------------------------------------------------------------------
package jac_pkg;

    // Moving-average window, per axis
    localparam int WINDOW_LENGTH = 10;
    localparam int POS_W         = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int MEM_DEPTH     = 2 * WINDOW_LENGTH;
    localparam int ADDR_W        = $clog2(MEM_DEPTH);

    // Sample mapping: (s - 2047) * 255 / 2047
    localparam int SAMPLE_W   = 12;
    localparam int MAP_CENTER = 2047;
    localparam int MAP_SCALE  = 255;
    localparam int MAP_W      = 9;   // signed -255..255
    localparam int CMAG_W     = 12;  // |s - 2047| <= 2048
    localparam int MPROD_W    = 19;  // 2048 * 255 < 2**19
    localparam int DIV_SHIFT  = 11;  // 2047 = 2**11 - 1

    // Running sum, signed, holds +/- WINDOW_LENGTH * 255
    localparam int SUM_MAX = WINDOW_LENGTH * MAP_SCALE;
    localparam int SUM_W   = $clog2(SUM_MAX + 1) + 1;
    localparam int MAG_W   = SUM_W - 1;

    // Divide by window then halve == truncating divide by 2 * window
    localparam int DIV_D     = 2 * WINDOW_LENGTH;
    localparam int DIV_LOG   = $clog2(DIV_D);
    localparam int DIV_K     = MAG_W + DIV_LOG;
    localparam int DIV_RECIP = ((2 ** DIV_K) + DIV_D - 1) / DIV_D;
    localparam int RECIP_W   = DIV_K - DIV_LOG + 2;
    localparam int SPROD_W   = MAG_W + RECIP_W;

    // Dead zone register
    localparam int DZ_W = 7;
    localparam logic [DZ_W-1:0] DZ_RESET = 7'd30;

    localparam int VAL_W  = 7;  // |average| <= 127
    localparam int BYTE_W = 8;

    // Window stage to scale stage
    typedef struct packed {
        logic                    valid;
        logic                    axis;
        logic signed [SUM_W-1:0] sum;
    } t_sum_beat;

    // Scale stage to packetiser
    typedef struct packed {
        logic             emit;
        logic             axis;
        logic             neg;
        logic [VAL_W-1:0] mag;
    } t_pkt_req;

endpackage

### hw/rtl/joystick_axis_conditioner.sv
// Path: an accepted sample is registered in window stages 1 and 2, then in the
//   scale stage, and its packet loads into the packetiser when that is free.
// Throughput: one sample per cycle while results fall in the dead zone; an
//   emitting sample stalls the pipeline until the packetiser can load it.
// Reset: synchronous, active low; window slots read as zero, sums and write
//   positions clear, dead zone returns to 30.
// ----------------------------------------------------------------------------
// Joystick axis conditioner top level
// Per-axis moving average over a window memory with a dead-zone packetiser.
// ----------------------------------------------------------------------------
module joystick_axis_conditioner (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_axis,
    input  logic [jac_pkg::SAMPLE_W-1:0]      i_sample,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [jac_pkg::BYTE_W-1:0]        o_packet_byte,
    output logic                              o_last,
    input  logic                              i_cfg_we,
    input  logic [jac_pkg::DZ_W-1:0]          i_cfg_wdata
);

    logic [jac_pkg::DZ_W-1:0] r_dead_zone;
    logic                     en;
    logic                     accept;
    logic                     can_load;
    jac_pkg::t_sum_beat       sum_beat;
    jac_pkg::t_pkt_req        pkt_req;

    // Dead-zone register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone <= jac_pkg::DZ_RESET;
        end else if (i_cfg_we) begin
            r_dead_zone <= i_cfg_wdata;
        end
    end

    // Pipeline advances unless a packet waits for the packetiser
    assign en      = !pkt_req.emit || can_load;
    assign o_stall = !en;
    assign accept  = i_valid && en;

    jac_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_accept (accept),
        .i_axis   (i_axis),
        .i_sample (i_sample),
        .o_beat   (sum_beat)
    );

    jac_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_beat      (sum_beat),
        .i_dead_zone (r_dead_zone),
        .o_req       (pkt_req)
    );

    jac_packetiser u_packetiser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (pkt_req.emit && en),
        .i_req         (pkt_req),
        .i_stall       (i_stall),
        .o_can_load    (can_load),
        .o_valid       (o_valid),
        .o_packet_byte (o_packet_byte),
        .o_last        (o_last)
    );

endmodule

### hw/rtl/jac_window.sv
// ----------------------------------------------------------------------------
// Joystick axis conditioner: window stage
// Maps each sample, reads the oldest window entry from memory, updates the
// axis running sum and writes the new value back over the oldest one.
// ----------------------------------------------------------------------------
`include "joystick_axis_conditioner_defines.svh"

module jac_window (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_accept,
    input  logic                                i_axis,
    input  logic [jac_pkg::SAMPLE_W-1:0]        i_sample,
    output jac_pkg::t_sum_beat                  o_beat
);

    // Window memory, one entry per axis and slot; valid bits give zero reset
    logic signed [jac_pkg::MAP_W-1:0] mem [0:jac_pkg::MEM_DEPTH-1];
    logic [jac_pkg::MEM_DEPTH-1:0]    r_mem_vld;

    logic [jac_pkg::POS_W-1:0]        r_pos [0:1];
    logic signed [jac_pkg::SUM_W-1:0] r_sum [0:1];

    // Stage 1 registers
    logic                             r1_valid;
    logic                             r1_axis;
    logic                             r1_neg;
    logic [jac_pkg::MPROD_W-1:0]      r1_prod;
    logic [jac_pkg::ADDR_W-1:0]       r1_addr;
    logic signed [jac_pkg::MAP_W-1:0] r_rd_data;
    logic                             r_rd_ok;

    // Stage 2 output register
    jac_pkg::t_sum_beat               r2_beat;

    logic signed [jac_pkg::SAMPLE_W:0]  centred;
    logic [jac_pkg::CMAG_W-1:0]         cmag;
    logic [jac_pkg::MPROD_W-1:0]        prod;
    logic [jac_pkg::POS_W-1:0]          cur_pos;
    logic [jac_pkg::POS_W-1:0]          n_pos;
    logic [jac_pkg::ADDR_W-1:0]         rd_addr;
    logic [jac_pkg::BYTE_W-1:0]         q0;
    logic [jac_pkg::DIV_SHIFT:0]        rem;
    logic [jac_pkg::BYTE_W-1:0]         quot;
    logic signed [jac_pkg::MAP_W-1:0]   mapped;
    logic signed [jac_pkg::MAP_W-1:0]   oldest;
    logic signed [jac_pkg::SUM_W-1:0]   n_sum;
    logic                               wr_en;

    // Stage 0: centre, magnitude and scale by 255
    assign centred = $signed({1'b0, i_sample})
                   - $signed((jac_pkg::SAMPLE_W+1)'(jac_pkg::MAP_CENTER));
    assign cmag    = centred[jac_pkg::SAMPLE_W] ? jac_pkg::CMAG_W'(-centred)
                                                : jac_pkg::CMAG_W'(centred);
    assign prod    = jac_pkg::MPROD_W'(cmag) * jac_pkg::MPROD_W'(jac_pkg::MAP_SCALE);

    // Slot address for this axis, and the wrapped write position
    assign cur_pos = r_pos[i_axis];
    assign n_pos   = (cur_pos == jac_pkg::POS_W'(jac_pkg::WINDOW_LENGTH - 1))
                   ? '0 : cur_pos + 1'b1;
    assign rd_addr = i_axis ? jac_pkg::ADDR_W'(jac_pkg::WINDOW_LENGTH) + jac_pkg::ADDR_W'(cur_pos)
                            : jac_pkg::ADDR_W'(cur_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r_pos[0] <= '0;
            r_pos[1] <= '0;
        end else if (i_en) begin
            r1_valid <= i_accept;
            if (i_accept) begin
                r_pos[i_axis] <= n_pos;
            end
        end
    end

    // Stage 0 payload and registered memory read
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r1_axis   <= i_axis;
            r1_neg    <= centred[jac_pkg::SAMPLE_W] ^ i_axis;
            r1_prod   <= prod;
            r1_addr   <= rd_addr;
            r_rd_data <= mem[rd_addr];
            r_rd_ok   <= r_mem_vld[rd_addr];
        end
    end

    // Stage 1: divide by 2**11 - 1 with a single correction step
    assign q0     = r1_prod[jac_pkg::MPROD_W-1:jac_pkg::DIV_SHIFT];
    assign rem    = (jac_pkg::DIV_SHIFT+1)'(r1_prod[jac_pkg::DIV_SHIFT-1:0])
                  + (jac_pkg::DIV_SHIFT+1)'(q0);
    assign quot   = (rem >= (jac_pkg::DIV_SHIFT+1)'(jac_pkg::MAP_CENTER)) ? q0 + 1'b1 : q0;
    assign mapped = r1_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    assign oldest = r_rd_ok ? r_rd_data : '0;
    assign n_sum  = r_sum[r1_axis] + jac_pkg::SUM_W'(mapped) - jac_pkg::SUM_W'(oldest);
    assign wr_en  = i_en && r1_valid;

    // Running sums, slot valid bits and the stage 2 beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum[0]  <= '0;
            r_sum[1]  <= '0;
            r_mem_vld <= '0;
            r2_beat.valid <= 1'b0;
        end else if (i_en) begin
            r2_beat.valid <= r1_valid;
            if (r1_valid) begin
                r_sum[r1_axis]     <= n_sum;
                r_mem_vld[r1_addr] <= 1'b1;
                r2_beat.axis       <= r1_axis;
                r2_beat.sum        <= n_sum;
            end
        end
    end

    // Write-back of the new value over the oldest slot
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r1_addr] <= mapped;
        end
    end

    assign o_beat = r2_beat;

    // Read of the next item never lands on the slot being written
    `JAC_ASSERT_NOW(a_no_rw_clash, wr_en && i_accept, r1_addr != rd_addr,
        "window read/write clash")
    // Running sums stay within the window bound
    `JAC_ASSERT_NOW(a_sum_range, r1_valid,
        (n_sum <= jac_pkg::SUM_W'(jac_pkg::SUM_MAX))
            && (n_sum >= -jac_pkg::SUM_W'(jac_pkg::SUM_MAX)),
        "running sum out of range")
    // The axis 0 write position never runs past the window
    `JAC_ASSERT_NOW(a_pos_range, 1'b1,
        (r_pos[0] < jac_pkg::POS_W'(jac_pkg::WINDOW_LENGTH))
            || (jac_pkg::WINDOW_LENGTH == (1 << jac_pkg::POS_W)),
        "write position past window")
    // An accepted beat always reaches stage 1
    `JAC_ASSERT_NEXT(a_accept_to_s1, i_en && i_accept, r1_valid, "accepted beat lost")

endmodule

### hw/rtl/jac_scale.sv
// ----------------------------------------------------------------------------
// Joystick axis conditioner: scale stage
// Truncating divide of the running sum by twice the window via a reciprocal
// multiply, then the dead-zone test.
// ----------------------------------------------------------------------------
module jac_scale (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  jac_pkg::t_sum_beat         i_beat,
    input  logic [jac_pkg::DZ_W-1:0]   i_dead_zone,
    output jac_pkg::t_pkt_req          o_req
);

    logic                          r3_valid;
    logic                          r3_axis;
    logic                          r3_neg;
    logic [jac_pkg::SPROD_W-1:0]   r3_prod;

    logic [jac_pkg::MAG_W-1:0]     mag;
    logic [jac_pkg::VAL_W-1:0]     q;

    // Magnitude of the sum, then reciprocal multiply
    assign mag = i_beat.sum[jac_pkg::SUM_W-1] ? jac_pkg::MAG_W'(-i_beat.sum)
                                              : jac_pkg::MAG_W'(i_beat.sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= i_beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_axis <= i_beat.axis;
            r3_neg  <= i_beat.sum[jac_pkg::SUM_W-1];
            r3_prod <= jac_pkg::SPROD_W'(mag)
                     * jac_pkg::SPROD_W'(jac_pkg::DIV_RECIP);
        end
    end

    // Quotient and dead-zone check
    assign q = r3_prod[jac_pkg::DIV_K +: jac_pkg::VAL_W];

    assign o_req.emit = r3_valid && (q > i_dead_zone);
    assign o_req.axis = r3_axis;
    assign o_req.neg  = r3_neg;
    assign o_req.mag  = q;

endmodule

### hw/rtl/jac_packetiser.sv
// ----------------------------------------------------------------------------
// Joystick axis conditioner: packetiser
// Holds one axis packet and sends it as four byte beats.
// ----------------------------------------------------------------------------
module jac_packetiser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  jac_pkg::t_pkt_req            i_req,
    input  logic                         i_stall,
    output logic                         o_can_load,
    output logic                         o_valid,
    output logic [jac_pkg::BYTE_W-1:0]   o_packet_byte,
    output logic                         o_last
);

    // Byte position within the packet
    localparam logic [1:0] BEAT_AXIS = 2'd0;
    localparam logic [1:0] BEAT_LOW  = 2'd1;
    localparam logic [1:0] BEAT_SIGN = 2'd2;
    localparam logic [1:0] BEAT_TERM = 2'd3;

    logic                        r_valid;
    logic [1:0]                  r_beat;
    logic                        r_axis;
    logic                        r_neg;
    logic [jac_pkg::BYTE_W-1:0]  r_low;

    logic                        done;

    assign done       = r_valid && !i_stall && (r_beat == BEAT_TERM);
    assign o_can_load = !r_valid || done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= BEAT_AXIS;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_beat  <= BEAT_AXIS;
        end else if (r_valid && !i_stall) begin
            if (r_beat == BEAT_TERM) begin
                r_valid <= 1'b0;
            end
            r_beat <= r_beat + 1'b1;
        end
    end

    // Packet payload, two's complement low byte
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_axis <= i_req.axis;
            r_neg  <= i_req.neg;
            r_low  <= i_req.neg ? -{1'b0, i_req.mag} : {1'b0, i_req.mag};
        end
    end

    // Byte select
    always_comb begin
        unique case (r_beat)
            BEAT_AXIS: o_packet_byte = {{(jac_pkg::BYTE_W-1){1'b0}}, r_axis};
            BEAT_LOW:  o_packet_byte = r_low;
            BEAT_SIGN: o_packet_byte = {jac_pkg::BYTE_W{r_neg}};
            BEAT_TERM: o_packet_byte = '1;
            default:   o_packet_byte = '0;
        endcase
    end

    assign o_valid = r_valid;
    assign o_last  = (r_beat == BEAT_TERM);

endmodule
